/* rtl/periodic_tick_timer_table_top_defines.svh */
// Assertion macros for the periodic tick timer table
`ifndef PERIODIC_TICK_TIMER_TABLE_TOP_DEFINES_SVH
`define PERIODIC_TICK_TIMER_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PTTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define PTTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PTTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PTTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/ptt_pkg.sv */
// Package: types, constants and helpers of the periodic tick timer table
package ptt_pkg;
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int TICK_W  = 64;
    localparam int PER_W   = 32;
    localparam int CMP_W   = IDX_W + 7;

    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_INSTALL   = 2'd1;
    localparam logic [1:0] REQ_UNINSTALL = 2'd2;
    localparam logic [1:0] REQ_READ      = 2'd3;

    localparam logic [1:0] KIND_FIRE    = 2'd0;
    localparam logic [1:0] KIND_NOFIRE  = 2'd1;
    localparam logic [1:0] KIND_INSTALL = 2'd2;
    localparam logic [1:0] KIND_COUNT   = 2'd3;

    localparam logic [5:0] FIRE_MAX = 6'd63;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] period;
        logic [5:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  resp_kind;
        logic [5:0]  slot_index;
        logic [63:0] tick_value;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_RD,
        S_CHK,
        S_DIV,
        S_DEC,
        S_END
    } t_state;

    function automatic logic [5:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+5:0] e;
        e = {6'b0, idx};
        return e[5:0];
    endfunction
endpackage

/* rtl/ptt_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/ptt_rem.sv */
// Bit-serial remainder unit: 64-bit dividend modulo 32-bit divisor, one bit per cycle
module ptt_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ptt_pkg::TICK_W-1:0]  i_dividend,
    input  logic [ptt_pkg::PER_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [ptt_pkg::PER_W-1:0]   o_rem
);
    import ptt_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [TICK_W-1:0] r_dvd;
    logic [PER_W-1:0]  r_dvs;
    logic [PER_W-1:0]  r_rem;
    logic [PER_W:0]    try_rem;
    logic [PER_W-1:0]  n_rem;

    always_comb begin
        try_rem = {r_rem, r_dvd[TICK_W-1]};
        if (try_rem >= {1'b0, r_dvs}) begin
            n_rem = PER_W'(try_rem - {1'b0, r_dvs});
        end else begin
            n_rem = try_rem[PER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TICK_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

/* rtl/periodic_tick_timer_table_top.sv */
// Top level: periodic tick timer table controller with period RAM
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// One item at a time. Install and read answer via S_PUT; uninstall gives none.
// A tick walks the slots in order, ending after the last slot or 63 fires; a
// candidate slot adds a RAM read plus the 64-step remainder unit (S_DIV).
// Synchronous active-low reset clears tick count and active marks; usage = 1.
// An output stall holds the walk until the pending result is taken.
`include "periodic_tick_timer_table_top_defines.svh"
module periodic_tick_timer_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ptt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ptt_pkg::t_out_item o_out_data
);
    import ptt_pkg::*;

    t_state            r_state, n_state;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [ENTRIES-1:0] r_active, n_active;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [5:0]        r_fire_cnt, n_fire_cnt;
    logic              r_pend_vld, n_pend_vld;
    logic [IDX_W-1:0]  r_pend, n_pend;
    t_out_item         r_res, n_res;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_out, n_out;

    logic              ld_out;
    logic              out_free;
    logic              accept;
    logic              ram_we;
    logic [PER_W-1:0]  ram_rdata;
    logic              rem_start;
    logic              rem_done;
    logic [PER_W-1:0]  rem_val;
    logic [CMP_W-1:0]  sl_ext;
    logic              full;
    logic              last_idx;

    ptt_ram #(.WIDTH(PER_W), .DEPTH(ENTRIES)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_used[IDX_W-1:0]),
        .i_wdata (i_in_data.period),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    ptt_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_tick),
        .i_divisor  (ram_rdata),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    assign out_free = !r_out_vld || !i_out_stall;
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign full     = r_used >= CNT_W'(ENTRIES);
    assign sl_ext   = CMP_W'(i_in_data.slot);
    assign last_idx = r_idx == IDX_W'(ENTRIES - 1);
    assign ram_we   = accept && (i_in_data.req_type == REQ_INSTALL) && !full;

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_active   = r_active;
        n_used     = r_used;
        n_idx      = r_idx;
        n_fire_cnt = r_fire_cnt;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_res      = r_res;
        n_out      = r_out;
        ld_out     = 1'b0;
        rem_start  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.req_type)
                        REQ_TICK: begin
                            n_tick     = r_tick + TICK_W'(1);
                            n_idx      = '0;
                            n_fire_cnt = '0;
                            n_pend_vld = 1'b0;
                            n_state    = S_RD;
                        end
                        REQ_INSTALL: begin
                            n_res = '{KIND_INSTALL, 6'd0, r_tick, 1'b1};
                            if (!full) begin
                                n_res.slot_index = to_slot(r_used[IDX_W-1:0]);
                                n_active[r_used[IDX_W-1:0]] = 1'b1;
                                n_used = r_used + CNT_W'(1);
                            end
                            n_state = S_PUT;
                        end
                        REQ_UNINSTALL: begin
                            if (sl_ext < CMP_W'(ENTRIES)) begin
                                n_active[sl_ext[IDX_W-1:0]] = 1'b0;
                            end
                        end
                        default: begin
                            n_res   = '{KIND_COUNT, 6'd0, r_tick, 1'b1};
                            n_state = S_PUT;
                        end
                    endcase
                end
            end
            S_PUT: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_active[r_idx] && ram_rdata != '0
                        && r_tick >= {{(TICK_W-PER_W){1'b0}}, ram_rdata}) begin
                    rem_start = 1'b1;
                    n_state   = S_DIV;
                end else if (last_idx) begin
                    n_state = S_END;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_DIV: begin
                if (rem_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (rem_val == '0) begin
                    if (!r_pend_vld || out_free) begin
                        if (r_pend_vld) begin
                            ld_out = 1'b1;
                            n_out  = '{KIND_FIRE, to_slot(r_pend), r_tick, 1'b0};
                        end
                        n_pend_vld = 1'b1;
                        n_pend     = r_idx;
                        n_fire_cnt = r_fire_cnt + 6'd1;
                        if (r_fire_cnt == FIRE_MAX - 6'd1 || last_idx) begin
                            n_state = S_END;
                        end else begin
                            n_idx   = r_idx + IDX_W'(1);
                            n_state = S_RD;
                        end
                    end
                end else if (last_idx) begin
                    n_state = S_END;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_END: begin
                if (out_free) begin
                    ld_out = 1'b1;
                    if (r_pend_vld) begin
                        n_out = '{KIND_FIRE, to_slot(r_pend), r_tick, 1'b1};
                    end else begin
                        n_out = '{KIND_NOFIRE, 6'd0, r_tick, 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ld_out) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick     <= '0;
            r_active   <= '0;
            r_used     <= CNT_W'(1);
            r_idx      <= '0;
            r_fire_cnt <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_active   <= n_active;
            r_used     <= n_used;
            r_idx      <= n_idx;
            r_fire_cnt <= n_fire_cnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `PTTT_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, ld_out, out_free)
    `PTTT_ASSERT_IMP(a_used_range, i_clk, i_rst_n, 1'b1,
        r_used != '0 && r_used <= CNT_W'(ENTRIES))
    `PTTT_ASSERT_IMP(a_rem_in_div, i_clk, i_rst_n, rem_done, r_state == S_DIV)
    `PTTT_ASSERT_NXT(a_start_to_div, i_clk, i_rst_n, rem_start, r_state == S_DIV)
endmodule
